[src/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants, codes and types of the disk seek scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TRACK_BITS  = 16;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL_BITS  = 21;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_RUN  = 1'b1
    } func_t;

    typedef enum logic {
        MODE_SSTF = 1'b0,
        MODE_SCAN = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_POSITION = 1'b0,
        REG_POLICY_MODE    = 1'b1
    } cfg_reg_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                  load;
        logic                  serve;
        logic                  clear;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] track;
    } cell_cmd_t;

    // search setup, stable while a wave runs
    typedef struct packed {
        logic [TRACK_BITS-1:0] head;
        logic [TRACK_BITS-1:0] start;
        mode_t                 mode;
        logic                  phase_down;
    } search_ctl_t;

    // best candidate travelling down the row
    typedef struct packed {
        logic                  tok;
        logic                  found;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] track;
        logic [TRACK_BITS-1:0] key;
    } cand_t;

endpackage

[src/dss_req_if.sv]
// ----------------------------------------------------------------------------
// dss_req_if
// Request channel: load a track or run the schedule.
// ----------------------------------------------------------------------------
interface dss_req_if;
    import dss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [TRACK_BITS-1:0] track;

    modport source (output valid, output func, output track, input ready);
    modport sink   (input valid, input func, input track, output ready);
endinterface

[src/dss_res_if.sv]
// ----------------------------------------------------------------------------
// dss_res_if
// Result channel: one served request per transfer.
// ----------------------------------------------------------------------------
interface dss_res_if;
    import dss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TRACK_BITS-1:0] served_track;
    logic [TRACK_BITS-1:0] seek_distance;
    logic [TOTAL_BITS-1:0] total_seek;
    logic                  last;

    modport source (output valid, output served_track, output seek_distance,
                    output total_seek, output last, input ready);
    modport sink   (input valid, input served_track, input seek_distance,
                    input total_seek, input last, output ready);
endinterface

[src/dss_cfg_if.sv]
// ----------------------------------------------------------------------------
// dss_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface dss_cfg_if;
    import dss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  addr;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/dss_cell.sv]
// ----------------------------------------------------------------------------
// dss_cell
// One queue entry: holds a track, compares it with the incoming candidate
// and passes the better one to the next cell.
// ----------------------------------------------------------------------------
module dss_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dss_pkg::IDX_BITS-1:0]  cell_idx,
    input  dss_pkg::cell_cmd_t            cmd,
    input  dss_pkg::search_ctl_t          ctl,
    input  dss_pkg::cand_t                cand_in,
    output dss_pkg::cand_t                cand_out
);
    import dss_pkg::*;

    logic [TRACK_BITS-1:0] track_reg;
    logic                  pend_reg;
    cand_t                 cand_reg;
    cand_t                 cand_next;
    logic                  hit;
    logic                  eligible;
    logic                  take;
    logic [TRACK_BITS-1:0] gap;
    logic [TRACK_BITS-1:0] key;

    assign hit = (cmd.idx == cell_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.load && hit)
        begin
            track_reg <= cmd.track;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.load && hit)
        begin
            pend_reg <= 1'b1;
        end
        else if (cmd.serve && hit)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_comb
    begin
        gap = (track_reg >= ctl.head) ? (track_reg - ctl.head) : (ctl.head - track_reg);
        eligible = pend_reg;
        key = gap;
        if (ctl.mode == MODE_SCAN)
        begin
            if (ctl.phase_down)
            begin
                key = ~track_reg;   // largest track wins
            end
            else
            begin
                key = track_reg;
                eligible = pend_reg && (track_reg >= ctl.start);
            end
        end
        // strict compare keeps the lower index on a tie
        take = eligible && (!cand_in.found || (key < cand_in.key));
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.track = track_reg;
            cand_next.key   = key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

[src/dss_chain.sv]
// ----------------------------------------------------------------------------
// dss_chain
// Row of queue cells; a search wave enters at cell zero and leaves the
// last cell with the chosen entry.
// ----------------------------------------------------------------------------
module dss_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dss_pkg::cell_cmd_t   cmd,
    input  dss_pkg::search_ctl_t ctl,
    input  logic                 launch,
    output dss_pkg::cand_t       tail
);
    import dss_pkg::*;

    cand_t seed;
    cand_t links [QUEUE_DEPTH];

    always_comb
    begin
        seed = '0;
        seed.tok = launch;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                dss_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_idx (IDX_BITS'(i)),
                    .cmd      (cmd),
                    .ctl      (ctl),
                    .cand_in  (seed),
                    .cand_out (links[i])
                );
            end
            else
            begin : g_rest
                dss_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_idx (IDX_BITS'(i)),
                    .cmd      (cmd),
                    .ctl      (ctl),
                    .cand_in  (links[i-1]),
                    .cand_out (links[i])
                );
            end
        end
    endgenerate

    assign tail = links[QUEUE_DEPTH-1];

endmodule

[src/disk_seek_scheduler.sv]
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// Disk arm scheduler, shortest seek first or scan up then down.
// ----------------------------------------------------------------------------
// Usage:
//   req: func = load stores one track (dropped when the queue
//   holds QUEUE_DEPTH entries, no result). func = run orders every stored
//   track from start_position and emits one res transfer per track, with
//   last set on the final one; the queue is empty afterwards. A run of an
//   empty queue gives no result.
//   cfg: addr 0 start_position, addr 1 policy_mode (0 SSTF, 1 SCAN).
//   Always ready; write only while no run is in progress.
//   Search: each result needs one search wave through the row of cells; in
//   SCAN mode the turn from upward to downward costs one extra wave. req is
//   not ready while a run is active.
//   A stalled res holds its result; the next search result then waits in
//   the block until the output register frees.
//   Reset empties the queue and clears start_position and policy_mode.
// ----------------------------------------------------------------------------
module disk_seek_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    dss_req_if.sink   req,
    dss_res_if.source res,
    dss_cfg_if.sink   cfg
);
    import dss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   served_cnt_reg;
    logic [TRACK_BITS-1:0] head_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TRACK_BITS-1:0] start_reg;
    mode_t                 mode_reg;
    logic                  phase_reg;
    logic                  launch_reg;
    logic [IDX_BITS-1:0]   pick_idx_reg;
    logic [TRACK_BITS-1:0] pick_track_reg;
    logic [TRACK_BITS-1:0] dist_reg;
    logic                  out_valid_reg;
    logic [TRACK_BITS-1:0] out_track_reg;
    logic [TRACK_BITS-1:0] out_dist_reg;
    logic [TOTAL_BITS-1:0] out_total_reg;
    logic                  out_last_reg;

    cell_cmd_t             cmd;
    search_ctl_t           ctl;
    cand_t                 tail;
    logic                  req_fire;
    logic                  load_ok;
    logic                  emit_go;
    logic                  is_last;
    logic [TOTAL_BITS:0]   total_sum;
    logic [TOTAL_BITS-1:0] total_sat;
    logic [TRACK_BITS-1:0] tail_dist;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_ok   = req_fire && (req.func == FUNC_LOAD)
                       && (count_reg < CNT_BITS'(QUEUE_DEPTH));
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || res.ready);
    assign is_last   = ((served_cnt_reg + CNT_BITS'(1)) == count_reg);

    assign total_sum = {1'b0, total_reg} + (TOTAL_BITS + 1)'(dist_reg);
    assign total_sat = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
    assign tail_dist = (tail.track >= head_reg) ? (tail.track - head_reg)
                                                : (head_reg - tail.track);

    always_comb
    begin
        cmd.load  = load_ok;
        cmd.serve = emit_go;
        cmd.clear = emit_go && is_last;
        cmd.idx   = emit_go ? pick_idx_reg : count_reg[IDX_BITS-1:0];
        cmd.track = req.track;
    end

    assign ctl.head       = head_reg;
    assign ctl.start      = start_reg;
    assign ctl.mode       = mode_reg;
    assign ctl.phase_down = phase_reg;

    dss_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .launch (launch_reg),
        .tail   (tail)
    );

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            mode_reg  <= MODE_SSTF;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.addr))
                REG_START_POSITION: start_reg <= cfg.data[TRACK_BITS-1:0];
                REG_POLICY_MODE:    mode_reg  <= mode_t'(cfg.data[0]);
                default:            ;
            endcase
        end
    end

    // search result and output capture, not reset
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEARCH) && tail.tok)
        begin
            pick_idx_reg   <= tail.idx;
            pick_track_reg <= tail.track;
            dist_reg       <= tail_dist;
        end
        if (emit_go)
        begin
            out_track_reg <= pick_track_reg;
            out_dist_reg  <= dist_reg;
            out_total_reg <= total_sat;
            out_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            head_reg       <= '0;
            total_reg      <= '0;
            phase_reg      <= 1'b0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            launch_reg <= 1'b0;
            if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (load_ok)
                    begin
                        count_reg <= count_reg + CNT_BITS'(1);
                    end
                    else if (req_fire && (req.func == FUNC_RUN))
                    begin
                        head_reg       <= start_reg;
                        total_reg      <= '0;
                        served_cnt_reg <= '0;
                        phase_reg      <= 1'b0;
                        if (count_reg != '0)
                        begin
                            launch_reg <= 1'b1;
                            state_reg  <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (tail.tok)
                    begin
                        if (tail.found)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else if ((mode_reg == MODE_SCAN) && !phase_reg)
                        begin
                            // nothing left above the start: turn around
                            phase_reg  <= 1'b1;
                            launch_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg  <= 1'b1;
                        head_reg       <= pick_track_reg;
                        total_reg      <= total_sat;
                        served_cnt_reg <= served_cnt_reg + CNT_BITS'(1);
                        if (is_last)
                        begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            launch_reg <= 1'b1;
                            state_reg  <= S_SEARCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.served_track  = out_track_reg;
    assign res.seek_distance = out_dist_reg;
    assign res.total_seek    = out_total_reg;
    assign res.last          = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_served_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (served_cnt_reg < count_reg))
        else $error("served count reached queue count during a run");

    a_search_finds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEARCH) && tail.tok)
        |-> (tail.found || ((mode_reg == MODE_SCAN) && !phase_reg)))
        else $error("search wave found no pending entry");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (out_valid_reg && (out_track_reg == head_reg)))
        else $error("served track not presented on the result channel");

endmodule
